[rtl/core/r2fft_pkg.sv]
// Package for the radix-2 complex FFT: store widths, item codes and the
// elaboration-time functions that build the quarter-wave twiddle tables.
// No dependencies.
`default_nettype none

package r2fft_pkg;

	localparam int DATA_W      = 28;
	localparam int SUM_W       = DATA_W + 3;
	localparam int POINTS_DEF  = 1024;
	localparam int TWIDDLE_DEF = 16;

	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_RUN   = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	localparam logic KIND_ACK = 1'b0;
	localparam logic KIND_BIN = 1'b1;

	// unsigned quotient by shift and subtract, used only at elaboration
	function automatic longint unsigned udiv(input longint unsigned n,
			input longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r    = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// sine (odd) or cosine of a Q30 angle below a quarter wave, Q30 result
	function automatic longint taylor_q30(input longint unsigned x, input bit odd);
		longint unsigned x2;
		longint unsigned term;
		longint unsigned k;
		longint          sum;
		bit              neg;
		x2   = (x * x + (64'd1 << 29)) >> 30;
		term = odd ? x : (64'd1 << 30);
		k    = odd ? 64'd2 : 64'd1;
		sum  = longint'(term);
		neg  = 1'b1;
		while (term != 0 && k < 40) begin
			term = (term * x2) >> 30;
			term = udiv(term, k * (k + 64'd1));
			k    = k + 64'd2;
			sum  = neg ? sum - longint'(term) : sum + longint'(term);
			neg  = !neg;
		end
		return (sum < 0) ? 64'sd0 : sum;
	endfunction

	// round a Q30 magnitude to tb-1 fraction bits and clamp below one
	function automatic longint tw_round(input longint m, input int tb);
		int     sh;
		longint v;
		longint vmax;
		sh   = 30 - (tb - 1);
		vmax = (64'sd1 <<< (tb - 1)) - 64'sd1;
		v    = (m + (64'sd1 <<< (sh - 1))) >>> sh;
		return (v > vmax) ? vmax : v;
	endfunction

	// clamp a butterfly sum to the store width
	function automatic logic signed [DATA_W-1:0] sat_store(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'({1'b0, {(DATA_W-1){1'b1}}});
		lo = -hi - SUM_W'(1);
		if (v > hi) begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end else if (v < lo) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end
		return v[DATA_W-1:0];
	endfunction

endpackage

`default_nettype wire

[rtl/core/r2fft_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module r2fft_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/core/radix2_complex_fft.sv]
// In-place radix-2 decimation-in-time complex FFT with a sample store.
// Depends on r2fft_pkg and r2fft_ram.
//
// Usage:
//  - Input channel (in_valid / in_stall): one word per item. func selects
//    write sample (stores sample_re/sample_im at index), run transform, or
//    read bin (returns the entry at index). func 3 is dropped silently.
//  - Output channel (out_valid / out_stall): kind 0 is the acknowledgement
//    of a transform (out_re = out_im = 0), kind 1 carries one bin.
//  - cfg_we / cfg_data write the inverse bit; write it only while idle.
// Sequence:
//  - A sample write goes straight into the store. A bin read goes through the
//    registered store read, then the word lands in the output register.
//  - A transform runs bit reversal (states BR_RA, BR_RB, BR_WA, BR_WB per swapped
//    pair, BR_RA alone per skipped index), then (POINTS/2)*log2(POINTS)
//    butterflies through states BF_RA, BF_RB, BF_MUL, BF_ADD, BF_WA, BF_WB, set by
//    the single read and single write port of the store; a forward transform
//    adds a 1/N scaling pass over every entry.
// Reset clears the controller, the inverse bit and the output valid; the
// store contents are undefined until written. While the receiver stalls,
// the output word holds and no new read or acknowledgement is issued.
`default_nettype none

module radix2_complex_fft
	import r2fft_pkg::*;
#(
	parameter int POINTS       = POINTS_DEF,
	parameter int TWIDDLE_BITS = TWIDDLE_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic                     cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [1:0]               func,
	input  wire logic [9:0]               index,
	input  wire logic signed [15:0]       sample_re,
	input  wire logic signed [15:0]       sample_im,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic                          kind,
	output logic signed [DATA_W-1:0]      out_re,
	output logic signed [DATA_W-1:0]      out_im
);

	localparam int LG   = $clog2(POINTS);
	localparam int N4   = POINTS / 4;
	localparam int QW   = (LG > 2) ? LG - 2 : 1;
	localparam int SW   = $clog2(LG + 1);
	localparam int TB   = TWIDDLE_BITS;
	localparam int PW   = DATA_W + TB;
	localparam int DXW  = DATA_W + 2;
	localparam int WW   = 2 * DATA_W;

	typedef logic [TB-1:0] quarter_t [N4];

	// quarter-wave magnitude tables, built at elaboration
	function automatic quarter_t build_quarter(input bit odd);
		quarter_t t;
		longint   ang;
		for (int r = 0; r < N4; r++) begin
			ang  = (HALF_PI_Q30 * longint'(r) + longint'(N4 / 2)) / N4;
			t[r] = TB'(tw_round(taylor_q30(longint'(ang), odd), TB));
		end
		return t;
	endfunction

	localparam quarter_t SIN_Q = build_quarter(1'b1);
	localparam quarter_t COS_Q = build_quarter(1'b0);

	function automatic logic [LG-1:0] bitrev(input logic [LG-1:0] v);
		logic [LG-1:0] r;
		for (int b = 0; b < LG; b++) begin
			r[b] = v[LG-1-b];
		end
		return r;
	endfunction

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BR_RA,
		ST_BR_RB,
		ST_BR_WA,
		ST_BR_WB,
		ST_BF_RA,
		ST_BF_RB,
		ST_BF_MUL,
		ST_BF_ADD,
		ST_BF_WA,
		ST_BF_WB,
		ST_SC_RD,
		ST_SC_WR,
		ST_ACK
	} state_t;

	state_t            state_q;
	logic              inverse_q;
	logic              rd_pend_q;
	logic [LG:0]       i_q;
	logic [LG:0]       j_q;
	logic [LG-1:0]     h_q;
	logic [SW-1:0]     st_q;

	// store port
	logic              we;
	logic [LG-1:0]     waddr;
	logic [WW-1:0]     wdata;
	logic [LG-1:0]     raddr;
	logic [WW-1:0]     rdata;

	// datapath registers
	logic signed [DATA_W-1:0] a_re_q, a_im_q;
	logic signed [TB-1:0]     tw_s_q, tw_c_q;
	logic signed [PW-1:0]     p_sbi_s1, p_cbr_s1, p_cbi_s1, p_sbr_s1;
	logic signed [DXW-1:0]    dx_s2, dy_s2;

	logic                     accept;
	logic                     out_free;
	logic [LG:0]              k_w, span_w, step_w, ik_w, i_nx, j_nx, lim_w;
	logic [LG-1:0]            rev_w;
	logic [QW-1:0]            tw_idx;
	logic                     tw_hi;
	logic signed [TB-1:0]     s_mag, c_mag, s_val, c_val;
	logic signed [DATA_W-1:0] b_re, b_im, rd_re, rd_im;
	logic signed [PW:0]       sum_x, sum_y;
	logic signed [DATA_W:0]   sc_re, sc_im;
	logic signed [DATA_W-1:0] add_re, add_im, sub_re, sub_im;

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || rd_pend_q || (out_valid && out_stall);
	assign accept   = in_valid && !in_stall;

	assign k_w    = (LG+1)'(1) << st_q;
	assign span_w = k_w << 1;
	assign step_w = (LG+1)'(POINTS) >> (st_q + SW'(1));
	assign ik_w   = i_q + k_w;
	assign lim_w  = (LG+1)'(POINTS) - k_w;
	assign i_nx   = i_q + span_w;
	assign j_nx   = j_q + (LG+1)'(1);
	assign rev_w  = bitrev(i_q[LG-1:0]);

	assign rd_re = rdata[DATA_W-1:0];
	assign rd_im = rdata[WW-1:DATA_W];
	assign b_re  = rd_re;
	assign b_im  = rd_im;

	// twiddle lookup: sine and cosine from the quarter tables by half-wave
	assign tw_idx = QW'(h_q & LG'(N4 - 1));
	assign tw_hi  = (h_q >= LG'(N4));
	assign s_mag  = signed'(SIN_Q[tw_idx]);
	assign c_mag  = signed'(COS_Q[tw_idx]);
	assign s_val  = tw_hi ? c_mag : s_mag;
	assign c_val  = tw_hi ? -s_mag : c_mag;

	always_ff @(posedge clk) begin
		tw_s_q <= inverse_q ? -s_val : s_val;
		tw_c_q <= c_val;
	end

	// butterfly arithmetic: products, rounded shift, then saturated sums
	assign sum_x = (PW+1)'(p_sbi_s1) + (PW+1)'(p_cbr_s1) + (PW+1)'(1 <<< (TB - 2));
	assign sum_y = (PW+1)'(p_cbi_s1) - (PW+1)'(p_sbr_s1) + (PW+1)'(1 <<< (TB - 2));

	assign add_re = sat_store(SUM_W'(a_re_q) + SUM_W'(dx_s2));
	assign add_im = sat_store(SUM_W'(a_im_q) + SUM_W'(dy_s2));
	assign sub_re = sat_store(SUM_W'(a_re_q) - SUM_W'(dx_s2));
	assign sub_im = sat_store(SUM_W'(a_im_q) - SUM_W'(dy_s2));

	assign sc_re = ((DATA_W+1)'(rd_re) + (DATA_W+1)'(POINTS / 2)) >>> LG;
	assign sc_im = ((DATA_W+1)'(rd_im) + (DATA_W+1)'(POINTS / 2)) >>> LG;

	always_ff @(posedge clk) begin
		if (state_q == ST_BF_RB || state_q == ST_BR_RB) begin
			a_re_q <= rd_re;
			a_im_q <= rd_im;
		end
		if (state_q == ST_BF_MUL) begin
			p_sbi_s1 <= tw_s_q * b_im;
			p_cbr_s1 <= tw_c_q * b_re;
			p_cbi_s1 <= tw_c_q * b_im;
			p_sbr_s1 <= tw_s_q * b_re;
		end
		if (state_q == ST_BF_ADD) begin
			dx_s2 <= DXW'(sum_x >>> (TB - 1));
			dy_s2 <= DXW'(sum_y >>> (TB - 1));
		end
	end

	// store address and write selection
	always_comb begin
		we    = 1'b0;
		waddr = i_q[LG-1:0];
		wdata = {add_im, add_re};
		raddr = i_q[LG-1:0];
		unique case (state_q)
			ST_IDLE: begin
				raddr = LG'(index);
				waddr = LG'(index);
				wdata = {DATA_W'(sample_im), DATA_W'(sample_re)};
				we    = accept && (func == FUNC_WRITE);
			end
			ST_BR_RB: begin
				raddr = rev_w;
			end
			ST_BR_WA: begin
				we    = 1'b1;
				wdata = rdata;
			end
			ST_BR_WB: begin
				we    = 1'b1;
				waddr = rev_w;
				wdata = {a_im_q, a_re_q};
			end
			ST_BF_RB: begin
				raddr = ik_w[LG-1:0];
			end
			ST_BF_WA: begin
				we = 1'b1;
			end
			ST_BF_WB: begin
				we    = 1'b1;
				waddr = ik_w[LG-1:0];
				wdata = {sub_im, sub_re};
			end
			ST_SC_WR: begin
				we    = 1'b1;
				wdata = {sc_im[DATA_W-1:0], sc_re[DATA_W-1:0]};
			end
			default: begin
			end
		endcase
	end

	r2fft_ram #(
		.WIDTH (WW),
		.DEPTH (POINTS)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// controller, counters and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			inverse_q <= 1'b0;
			rd_pend_q <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			h_q       <= '0;
			st_q      <= '0;
			out_valid <= 1'b0;
			kind      <= KIND_ACK;
			out_re    <= '0;
			out_im    <= '0;
		end else begin
			if (cfg_we) begin
				inverse_q <= cfg_data;
			end
			// a bin read passes through the registered store read before it lands
			rd_pend_q <= accept && (func == FUNC_READ);
			if (rd_pend_q) begin
				out_valid <= 1'b1;
				kind      <= KIND_BIN;
				out_re    <= rd_re;
				out_im    <= rd_im;
			end else if (out_valid && !out_stall && state_q != ST_ACK) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && func == FUNC_RUN) begin
						i_q     <= '0;
						state_q <= ST_BR_RA;
					end
				end
				ST_BR_RA: begin
					if (i_q[LG]) begin
						i_q     <= '0;
						j_q     <= '0;
						h_q     <= '0;
						st_q    <= '0;
						state_q <= ST_BF_RA;
					end else if (i_q[LG-1:0] < rev_w) begin
						state_q <= ST_BR_RB;
					end else begin
						i_q <= i_q + (LG+1)'(1);
					end
				end
				ST_BR_RB: state_q <= ST_BR_WA;
				ST_BR_WA: state_q <= ST_BR_WB;
				ST_BR_WB: begin
					i_q     <= i_q + (LG+1)'(1);
					state_q <= ST_BR_RA;
				end
				ST_BF_RA:  state_q <= ST_BF_RB;
				ST_BF_RB:  state_q <= ST_BF_MUL;
				ST_BF_MUL: state_q <= ST_BF_ADD;
				ST_BF_ADD: state_q <= ST_BF_WA;
				ST_BF_WA:  state_q <= ST_BF_WB;
				ST_BF_WB: begin
					state_q <= ST_BF_RA;
					if (i_nx < lim_w) begin
						i_q <= i_nx;
					end else if (j_nx != k_w) begin
						j_q <= j_nx;
						i_q <= j_nx;
						h_q <= h_q + step_w[LG-1:0];
					end else if (st_q != SW'(LG - 1)) begin
						st_q <= st_q + SW'(1);
						j_q  <= '0;
						i_q  <= '0;
						h_q  <= '0;
					end else begin
						i_q     <= '0;
						state_q <= inverse_q ? ST_ACK : ST_SC_RD;
					end
				end
				ST_SC_RD: state_q <= ST_SC_WR;
				ST_SC_WR: begin
					i_q     <= i_q + (LG+1)'(1);
					state_q <= (i_q == (LG+1)'(POINTS - 1)) ? ST_ACK : ST_SC_RD;
				end
				ST_ACK: begin
					// load the acknowledgement once the previous word leaves
					if (out_free) begin
						out_valid <= 1'b1;
						kind      <= KIND_ACK;
						out_re    <= '0;
						out_im    <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a butterfly writes its lower leg right after its upper leg
	a_bf_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BF_WB |-> $past(state_q) == ST_BF_WA)
		else $error("butterfly write order broken");

	// a read lands only in an empty output register
	a_rd_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> !out_valid)
		else $error("bin read overwrites pending output");

	// a read result appears as bin data on the next cycle
	a_rd_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |=> out_valid && kind == KIND_BIN)
		else $error("bin read lost");

	// bit reversal swaps each pair once, from its lower index
	a_br_pair: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BR_WA |-> i_q[LG-1:0] < rev_w)
		else $error("bit reversal swaps a pair twice");

	// no item is taken while the transform runs
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall)
		else $error("item accepted during transform");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for radix2_complex_fft: fills the sample store, runs forward and
// inverse transforms and reads bins back, comparing each output word against a predictor.
// Depends on r2fft_pkg and the RTL of radix2_complex_fft.
`default_nettype none

module tb;
	import r2fft_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS      = 1024;
	localparam int LOG_N     = 10;
	localparam int TAB_LEN   = NPTS + NPTS / 4;
	localparam int TW_BITS   = 16;
	localparam int MAX_CYCLE = 3000000;

	typedef struct {
		logic                     kind;
		logic signed [DATA_W-1:0] re;
		logic signed [DATA_W-1:0] im;
	} bin_word_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic                     cfg_data = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [1:0]               func = FUNC_NONE;
	logic [9:0]               index = '0;
	logic signed [15:0]       sample_re = '0;
	logic signed [15:0]       sample_im = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     kind;
	logic signed [DATA_W-1:0] out_re;
	logic signed [DATA_W-1:0] out_im;

	// predicted store contents, twiddles and mode
	longint    store_re[NPTS];
	longint    store_im[NPTS];
	longint    sin_tab[TAB_LEN];
	bit        inv_mode;
	bin_word_t pending_bins[$];

	int  error_cnt = 0;
	int  cycle_cnt = 0;
	int  burst_left = 0;
	bit  hold_req = 1'b0;

	radix2_complex_fft #(.POINTS(NPTS), .TWIDDLE_BITS(TW_BITS)) DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .func(func), .index(index),
		.sample_re(sample_re), .sample_im(sample_im), .out_valid(out_valid),
		.out_stall(out_stall), .kind(kind), .out_re(out_re), .out_im(out_im)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > MAX_CYCLE) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// ---------------- predictor ----------------

	// Q30 sine or cosine of an angle under a quarter wave, by Taylor series
	function automatic longint series_q30(longint unsigned ang, bit odd);
		longint unsigned sq;
		longint unsigned term;
		longint unsigned k;
		longint          acc;
		bit              sub;
		sq   = (ang * ang + (64'd1 << 29)) >> 30;
		term = odd ? ang : (64'd1 << 30);
		k    = odd ? 2 : 1;
		acc  = longint'(term);
		sub  = 1'b1;
		while (term != 0 && k < 40) begin
			term = ((term * sq) >> 30) / (k * (k + 1));
			k    = k + 2;
			acc  = sub ? acc - longint'(term) : acc + longint'(term);
			sub  = !sub;
		end
		return (acc < 0) ? 0 : acc;
	endfunction

	function automatic void build_sine_table();
		int     quarter;
		int     pos;
		int     quad;
		int     r;
		longint ang;
		longint mag;
		quarter = NPTS / 4;
		for (int i = 0; i < TAB_LEN; i++) begin
			pos  = i % NPTS;
			quad = pos / quarter;
			r    = pos % quarter;
			ang  = (HALF_PI_Q30 * r + quarter / 2) / quarter;
			mag  = series_q30(ang, quad % 2 == 0);
			mag  = (mag + (64'sd1 <<< (30 - TW_BITS))) >>> (31 - TW_BITS);
			if (mag > (64'sd1 <<< (TW_BITS - 1)) - 1)
				mag = (64'sd1 <<< (TW_BITS - 1)) - 1;
			sin_tab[i] = (quad >= 2) ? -mag : mag;
		end
	endfunction

	function automatic longint clamp28(longint v);
		if (v > 134217727)
			return 134217727;
		if (v < -134217728)
			return -134217728;
		return v;
	endfunction

	function automatic void transform_store();
		int     rev;
		int     span;
		int     stride;
		int     tw;
		int     hi;
		longint t;
		longint c;
		longint s;
		longint dx;
		longint dy;
		longint xr;
		longint xi;
		// bit-reversal permutation
		for (int i = 0; i < NPTS; i++) begin
			rev = 0;
			for (int b = 0; b < LOG_N; b++)
				rev = (rev << 1) | ((i >> b) & 1);
			if (i < rev) begin
				t = store_re[i]; store_re[i] = store_re[rev]; store_re[rev] = t;
				t = store_im[i]; store_im[i] = store_im[rev]; store_im[rev] = t;
			end
		end
		// butterfly stages
		for (int k = 1; k < NPTS; k = span) begin
			span   = 2 * k;
			stride = NPTS / span;
			tw     = 0;
			for (int j = 0; j < k; j++) begin
				c = sin_tab[(tw + NPTS / 4) % TAB_LEN];
				s = sin_tab[tw % TAB_LEN];
				if (inv_mode)
					s = -s;
				for (int i = j; i + k < NPTS; i += span) begin
					hi = i + k;
					dx = (s * store_im[hi] + c * store_re[hi] + (64'sd1 <<< (TW_BITS - 2)))
						>>> (TW_BITS - 1);
					dy = (c * store_im[hi] - s * store_re[hi] + (64'sd1 <<< (TW_BITS - 2)))
						>>> (TW_BITS - 1);
					xr = store_re[i];
					xi = store_im[i];
					store_re[hi] = clamp28(xr - dx);
					store_re[i]  = clamp28(xr + dx);
					store_im[hi] = clamp28(xi - dy);
					store_im[i]  = clamp28(xi + dy);
				end
				tw += stride;
			end
		end
		// forward: divide by N, round half up
		if (!inv_mode) begin
			for (int i = 0; i < NPTS; i++) begin
				store_re[i] = (store_re[i] + NPTS / 2) >>> LOG_N;
				store_im[i] = (store_im[i] + NPTS / 2) >>> LOG_N;
			end
		end
	endfunction

	// apply one accepted word to the predicted state, queue what it returns
	function automatic void predict_word(logic [1:0] f, logic [9:0] idx,
			logic signed [15:0] re, logic signed [15:0] im);
		bin_word_t w;
		case (f)
			FUNC_WRITE: begin
				store_re[idx] = longint'(re);
				store_im[idx] = longint'(im);
			end
			FUNC_RUN: begin
				transform_store();
				w.kind = KIND_ACK;
				w.re   = '0;
				w.im   = '0;
				pending_bins.push_back(w);
			end
			FUNC_READ: begin
				w.kind = KIND_BIN;
				w.re   = store_re[idx][DATA_W-1:0];
				w.im   = store_im[idx][DATA_W-1:0];
				pending_bins.push_back(w);
			end
			default: ;
		endcase
	endfunction

	// ---------------- output checker ----------------

	always @(posedge clk) begin
		bin_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bins.size() == 0) begin
				$error("unexpected output word kind=%0d re=%0d im=%0d", kind, out_re, out_im);
				error_cnt++;
			end else begin
				w = pending_bins.pop_front();
				if (kind !== w.kind) begin
					$error("kind: expected %0d, got %0d", w.kind, kind);
					error_cnt++;
				end
				if (out_re !== w.re) begin
					$error("out_re: expected %0d, got %0d", w.re, out_re);
					error_cnt++;
				end
				if (out_im !== w.im) begin
					$error("out_im: expected %0d, got %0d", w.im, out_im);
					error_cnt++;
				end
			end
		end
	end

	// ---------------- receiver stall pattern ----------------

	initial begin
		int mode;
		mode = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				// long hold-off so the block backs up into its input
				hold_req = 1'b0;
				for (int n = 0; n < 400; n++) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			if (cycle_cnt % 150 == 0)
				mode = $urandom_range(0, 2);
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	// ---------------- sender helpers ----------------

	// offer one word and hold it until accepted; valid stays high afterwards
	task automatic send_word(logic [1:0] f, logic [9:0] idx,
			logic signed [15:0] re, logic signed [15:0] im);
		in_valid  <= 1'b1;
		func      <= f;
		index     <= idx;
		sample_re <= re;
		sample_im <= im;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_word(f, idx, re, im);
	endtask

	task automatic idle_cycles(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// bursts of random length separated by random gaps
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			idle_cycles($urandom_range(1, 6));
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end
	endtask

	task automatic drain();
		idle_cycles(1);
		while (pending_bins.size() != 0)
			@(posedge clk);
		// let a trailing sample write settle before touching the register
		repeat (8) @(posedge clk);
	endtask

	task automatic set_inverse(bit v);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		inv_mode = v;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			default: return 16'($urandom());
		endcase
	endfunction

	// ---------------- tests ----------------

	task automatic test_directed();
		send_word(FUNC_WRITE, 10'd0, 16'sh7FFF, 16'sh8000);
		send_word(FUNC_WRITE, 10'd1023, 16'sh8000, 16'sh7FFF);
		send_word(FUNC_READ, 10'd0, '0, '0);
		send_word(FUNC_READ, 10'd1023, '0, '0);
		// unknown func is dropped
		send_word(FUNC_NONE, 10'h3FF, 16'sh7FFF, 16'sh7FFF);
		send_word(FUNC_READ, 10'd512, '0, '0);
		send_word(FUNC_RUN, 10'd0, '0, '0);
		send_word(FUNC_READ, 10'd0, '0, '0);
		send_word(FUNC_READ, 10'd1, '0, '0);
		send_word(FUNC_READ, 10'd1023, '0, '0);
		set_inverse(1'b1);
		send_word(FUNC_RUN, 10'd0, '0, '0);
		send_word(FUNC_READ, 10'd0, '0, '0);
		send_word(FUNC_READ, 10'd341, '0, '0);
		set_inverse(1'b0);
	endtask

	// full-scale DC through three unscaled inverse passes drives the store into clamp;
	// the fill also writes every entry before any read or transform
	task automatic test_saturation();
		for (int i = 0; i < NPTS; i++) begin
			send_word(FUNC_WRITE, 10'(i), (i % 2) ? 16'sh7FFF : 16'sh7FFE, 16'sh8000);
			pace();
		end
		set_inverse(1'b1);
		send_word(FUNC_RUN, 10'd0, '0, '0);
		send_word(FUNC_RUN, 10'd0, '0, '0);
		send_word(FUNC_RUN, 10'd0, '0, '0);
		for (int i = 0; i < 8; i++)
			send_word(FUNC_READ, 10'((i < 4) ? i : NPTS - i), '0, '0);
		set_inverse(1'b0);
		send_word(FUNC_RUN, 10'd0, '0, '0);
		send_word(FUNC_READ, 10'd0, '0, '0);
	endtask

	// receiver holds off while reads keep coming back to back
	task automatic test_backpressure();
		drain();
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++)
			send_word(FUNC_READ, 10'($urandom()), '0, '0);
		drain();
	endtask

	task automatic test_random_traffic();
		int pick;
		for (int phase = 0; phase < 4; phase++) begin
			set_inverse(1'(phase % 2));
			for (int n = 0; n < 40; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 45)
					send_word(FUNC_WRITE, 10'($urandom()), rand_sample(), rand_sample());
				else if (pick < 92)
					send_word(FUNC_READ, 10'($urandom()), '0, '0);
				else if (pick < 98 || n != 20)
					send_word(FUNC_NONE, 10'($urandom()), 16'($urandom()),
						16'($urandom()));
				else
					send_word(FUNC_RUN, 10'($urandom()), '0, '0);
				// at most two transforms per phase keep the run short
				if (n == 20)
					send_word(FUNC_RUN, 10'($urandom()), '0, '0);
				pace();
			end
			// pause the sender until every result is back
			drain();
		end
	endtask

	initial begin
		for (int i = 0; i < NPTS; i++) begin
			store_re[i] = 0;
			store_im[i] = 0;
		end
		build_sine_table();
		inv_mode = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_saturation();
		test_directed();
		test_backpressure();
		test_random_traffic();

		drain();
		repeat (20) @(posedge clk);
		if (error_cnt == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
